// ===== src/weighted_interrupt_target_selector_defines.svh =====
// ---------------------------------------------------------------------------
// Weighted interrupt target selector: assertion macros
// Shared property shorthands. Each use expects clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_INTERRUPT_TARGET_SELECTOR_DEFINES_SVH
`define WEIGHTED_INTERRUPT_TARGET_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WITS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WITS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wits_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Weighted interrupt target selector: shared package
// Beat and configuration types, command and policy codes, and the
// microprogram that drives the selector datapath.
// ---------------------------------------------------------------------------
package wits_pkg;

  localparam int unsigned NUM_CPUS_DEF    = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned CPU_ID_BITS = 4;
  localparam int unsigned MASK_BITS   = 16;
  localparam int unsigned WEIGHT_W    = 15;
  localparam int unsigned FACTOR_W    = 5;

  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_REDIST = 2'd3;

  localparam logic [1:0] POL_REQ = 2'd0;
  localparam logic [1:0] POL_RR  = 2'd1;
  localparam logic [1:0] POL_WLL = 2'd2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT_RST = 15'd1000;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        requesting_cpu;
    logic [3:0]        target_id;
    logic signed [15:0] nexus_weight;
    logic signed [15:0] device_weight;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]          chosen_cpu;
    logic                found;
    logic                establish;
    logic [WEIGHT_W-1:0] applied_weight;
    logic [WEIGHT_W-1:0] redist_cap;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]           policy;
    logic [MASK_BITS-1:0] online_mask;
    logic [MASK_BITS-1:0] enable_mask;
    logic [FACTOR_W-1:0]  weight_factor;
    logic [WEIGHT_W-1:0]  weight_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    policy:        POL_WLL,
    online_mask:   16'hFFFF,
    enable_mask:   16'hFFFF,
    weight_factor: 5'd2,
    weight_limit:  WEIGHT_LIMIT_RST
  };

  // Microprogram addresses.
  typedef logic [3:0] upc_t;

  localparam upc_t UA_IDLE   = 4'd0;
  localparam upc_t UA_DISP   = 4'd1;
  localparam upc_t UA_PICK   = 4'd2;
  localparam upc_t UA_NORM   = 4'd3;
  localparam upc_t UA_WALK   = 4'd4;
  localparam upc_t UA_DRAIN  = 4'd5;
  localparam upc_t UA_COMMIT = 4'd6;
  localparam upc_t UA_ADD_RD = 4'd7;
  localparam upc_t UA_ADD_WR = 4'd8;
  localparam upc_t UA_SUB_RD = 4'd9;
  localparam upc_t UA_SUB_WR = 4'd10;
  localparam upc_t UA_REDIST = 4'd11;
  localparam upc_t UA_FIN    = 4'd12;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_HOLD,
    SEQ_DISP
  } seq_op_e;

  typedef enum logic [1:0] {
    C_NO_IN,
    C_NORM_HI,
    C_CNT_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PICK,
    DP_NORM,
    DP_WALK,
    DP_COMMIT,
    DP_RD_TGT,
    DP_ADD,
    DP_SUB,
    DP_REDIST,
    DP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    R_PICK,
    R_WALK,
    R_ADD,
    R_SUB,
    R_NONE,
    R_REDIST
  } route_e;

  typedef struct packed {
    seq_op_e op;
    cond_e   cond;
    upc_t    target;
    dp_op_e  dp;
  } uword_t;

  typedef struct packed {
    logic   norm_hi;
    logic   cnt_more;
    route_e route;
  } dp_stat_t;

  // Control store. A HOLD word stays on its own address while its condition
  // is true and goes to its target once the condition clears.
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    w = '{op: SEQ_JUMP, cond: C_NO_IN, target: UA_IDLE, dp: DP_NOP};
    case (addr)
      UA_IDLE:   w = '{op: SEQ_HOLD, cond: C_NO_IN,    target: UA_DISP,  dp: DP_LOAD};
      UA_DISP:   w = '{op: SEQ_DISP, cond: C_NO_IN,    target: UA_IDLE,  dp: DP_NOP};
      UA_PICK:   w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_FIN,   dp: DP_PICK};
      UA_NORM:   w = '{op: SEQ_HOLD, cond: C_NORM_HI,  target: UA_WALK,  dp: DP_NORM};
      UA_WALK:   w = '{op: SEQ_HOLD, cond: C_CNT_MORE, target: UA_DRAIN, dp: DP_WALK};
      UA_DRAIN:  w = '{op: SEQ_NEXT, cond: C_NO_IN,    target: UA_IDLE,  dp: DP_NOP};
      UA_COMMIT: w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_FIN,   dp: DP_COMMIT};
      UA_ADD_RD: w = '{op: SEQ_NEXT, cond: C_NO_IN,    target: UA_IDLE,  dp: DP_RD_TGT};
      UA_ADD_WR: w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_FIN,   dp: DP_ADD};
      UA_SUB_RD: w = '{op: SEQ_NEXT, cond: C_NO_IN,    target: UA_IDLE,  dp: DP_RD_TGT};
      UA_SUB_WR: w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_FIN,   dp: DP_SUB};
      UA_REDIST: w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_FIN,   dp: DP_REDIST};
      UA_FIN:    w = '{op: SEQ_HOLD, cond: C_OUT_BUSY, target: UA_IDLE,  dp: DP_OUT};
      default:   w = '{op: SEQ_JUMP, cond: C_NO_IN,    target: UA_IDLE,  dp: DP_NOP};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/wits_seq.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Weighted interrupt target selector: microsequencer
// Steps through the control store, evaluates jump conditions and dispatches
// each accepted command to its routine.
// ---------------------------------------------------------------------------
module wits_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_fire_i,
  input  wire logic               out_busy_i,
  input  wire wits_pkg::dp_stat_t stat_i,
  output wits_pkg::dp_op_e        op_o,
  output logic                    idle_o
);

  wits_pkg::upc_t   upc_q, upc_d;
  wits_pkg::uword_t uw;
  logic             cond_hit;

  assign uw = wits_pkg::ucode(upc_q);

  always_comb begin
    case (uw.cond)
      wits_pkg::C_NO_IN:    cond_hit = !in_fire_i;
      wits_pkg::C_NORM_HI:  cond_hit = stat_i.norm_hi;
      wits_pkg::C_CNT_MORE: cond_hit = stat_i.cnt_more;
      wits_pkg::C_OUT_BUSY: cond_hit = out_busy_i;
      default:              cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.op)
      wits_pkg::SEQ_NEXT: upc_d = upc_q + 1'b1;
      wits_pkg::SEQ_JUMP: upc_d = uw.target;
      wits_pkg::SEQ_HOLD: upc_d = cond_hit ? upc_q : uw.target;
      wits_pkg::SEQ_DISP: begin
        case (stat_i.route)
          wits_pkg::R_PICK:   upc_d = wits_pkg::UA_PICK;
          wits_pkg::R_WALK:   upc_d = wits_pkg::UA_NORM;
          wits_pkg::R_ADD:    upc_d = wits_pkg::UA_ADD_RD;
          wits_pkg::R_SUB:    upc_d = wits_pkg::UA_SUB_RD;
          wits_pkg::R_REDIST: upc_d = wits_pkg::UA_REDIST;
          default:            upc_d = wits_pkg::UA_FIN;
        endcase
      end
      default: upc_d = wits_pkg::UA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= wits_pkg::UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign op_o   = uw.dp;
  assign idle_o = (upc_q == wits_pkg::UA_IDLE);

endmodule
`default_nettype wire

// ===== src/wits_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Weighted interrupt target selector: datapath
// Per-CPU load memory, walk pointer and counter, best-candidate registers,
// saturating weight update and the redistribution cap.
// ---------------------------------------------------------------------------
module wits_dp #(
  parameter int unsigned NUM_CPUS    = wits_pkg::NUM_CPUS_DEF,
  parameter int unsigned WEIGHT_BITS = wits_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wits_pkg::dp_op_e    op_i,
  input  wire logic                in_fire_i,
  input  wire wits_pkg::in_beat_t  in_data_i,
  input  wire wits_pkg::cfg_t      cfg_i,
  output wits_pkg::dp_stat_t       stat_o,
  output wits_pkg::out_beat_t      res_o
);

  localparam int unsigned CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned PW    = (CW > wits_pkg::CPU_ID_BITS) ? CW : wits_pkg::CPU_ID_BITS;
  localparam int unsigned NW    = $clog2(NUM_CPUS + 1);
  localparam int unsigned WW    = wits_pkg::WEIGHT_W;
  localparam int unsigned SW    = ((WEIGHT_BITS > WW) ? WEIGHT_BITS : WW) + 1;
  localparam int unsigned PRODW = WW + wits_pkg::FACTOR_W;

  localparam logic [WEIGHT_BITS-1:0] LOAD_MAX = {WEIGHT_BITS{1'b1}};
  localparam logic [PW:0]            NUM_P    = (PW + 1)'(NUM_CPUS);
  localparam logic [PW:0]            MASK_LIM = (PW + 1)'(wits_pkg::MASK_BITS);
  localparam logic [PW-1:0]          LAST_ID  = PW'(NUM_CPUS - 1);
  localparam logic [PW-1:0]          NUM_SUB  = PW'(NUM_CPUS);

  wits_pkg::in_beat_t  item_q;
  wits_pkg::out_beat_t res_q, res_d;
  wits_pkg::route_e    route;

  logic [PW-1:0]          pos_q, pos_d, pos_adv, rd_id_q, best_id_q, best_id_d;
  logic [NW-1:0]          cnt_q, cnt_d;
  logic                   have_q, have_d, rd_v_q, rd_v_d;
  logic [3:0]             last_q, last_d, start;
  logic                   last_v_q, last_v_d;
  logic [WW-1:0]          largest_q, largest_d;
  logic [NUM_CPUS-1:0]    vld_q, vld_d;
  logic                   norm_hi, cnt_more;

  logic [WEIGHT_BITS-1:0] load_mem [NUM_CPUS];
  logic [WEIGHT_BITS-1:0] rd_raw_q, rd_val, best_load_q, best_load_d, wr_data;
  logic                   rd_hit_q, rd_en, wr_en;
  logic [CW-1:0]          rd_addr, tgt_addr;
  logic [PW-1:0]          tgt_ext;
  logic                   tgt_ok;

  logic [WW-1:0]          add_w, sub_w;
  logic                   add_est;
  logic [SW-1:0]          sum, room, diff;
  logic [PRODW-1:0]       prod;
  logic [15:0]            elig_mask;
  logic                   cand_elig, cand_take;

  // Walk start: after the last chosen CPU, or after the requester if none yet.
  assign start    = last_v_q ? last_q : in_data_i.requesting_cpu;
  assign pos_adv  = (pos_q == LAST_ID) ? '0 : pos_q + 1'b1;
  assign tgt_ext  = PW'(item_q.target_id);
  assign tgt_ok   = ({1'b0, tgt_ext} < NUM_P);
  assign tgt_addr = tgt_ext[CW-1:0];
  assign rd_val   = rd_hit_q ? rd_raw_q : '0;

  always_comb begin
    add_est = 1'b0;
    if (item_q.device_weight[15]) begin
      if (!item_q.nexus_weight[15] && (item_q.nexus_weight != '0)) begin
        add_w   = item_q.nexus_weight[WW-1:0];
        add_est = 1'b1;
      end else begin
        add_w = '0;
      end
    end else begin
      add_w = item_q.device_weight[WW-1:0];
    end
  end

  assign sub_w = item_q.device_weight[15] ? '0 : item_q.device_weight[WW-1:0];
  assign sum   = SW'(rd_val) + SW'(add_w);
  assign room  = SW'(LOAD_MAX) - SW'(rd_val);
  assign diff  = SW'(rd_val) - SW'(sub_w);
  assign prod  = PRODW'(largest_q) * PRODW'(cfg_i.weight_factor);

  assign elig_mask = cfg_i.online_mask & cfg_i.enable_mask;
  assign cand_elig = ({1'b0, rd_id_q} < MASK_LIM) && elig_mask[rd_id_q[3:0]];
  // Flat round robin keeps the first eligible CPU; otherwise a strictly
  // smaller load replaces the best so far.
  assign cand_take = cand_elig &&
                     (!have_q || ((cfg_i.policy != wits_pkg::POL_RR) &&
                                  (rd_val < best_load_q)));

  always_comb begin
    case (item_q.cmd)
      wits_pkg::CMD_SELECT:
        route = (cfg_i.policy == wits_pkg::POL_REQ) ? wits_pkg::R_PICK
                                                   : wits_pkg::R_WALK;
      wits_pkg::CMD_ADD:
        route = (cfg_i.policy == wits_pkg::POL_WLL) ? wits_pkg::R_ADD
                                                   : wits_pkg::R_NONE;
      wits_pkg::CMD_REMOVE:
        route = (cfg_i.policy == wits_pkg::POL_WLL) ? wits_pkg::R_SUB
                                                   : wits_pkg::R_NONE;
      default:
        route = wits_pkg::R_REDIST;
    endcase
  end

  assign norm_hi  = ({1'b0, pos_q} >= NUM_P);
  assign cnt_more = (cnt_q != NW'(1));
  assign stat_o   = '{norm_hi: norm_hi, cnt_more: cnt_more, route: route};

  always_comb begin
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    have_d      = have_q;
    best_id_d   = best_id_q;
    best_load_d = best_load_q;
    last_d      = last_q;
    last_v_d    = last_v_q;
    largest_d   = largest_q;
    vld_d       = vld_q;
    res_d       = res_q;
    rd_v_d      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = tgt_addr;
    wr_en       = 1'b0;
    wr_data     = rd_val;

    // The entry read in the previous walk cycle is judged here.
    if (rd_v_q && cand_take) begin
      have_d      = 1'b1;
      best_id_d   = rd_id_q;
      best_load_d = rd_val;
    end

    case (op_i)
      wits_pkg::DP_LOAD: begin
        if (in_fire_i) begin
          pos_d  = PW'(start);
          cnt_d  = NW'(NUM_CPUS);
          have_d = 1'b0;
          res_d  = '0;
        end
      end
      wits_pkg::DP_PICK: begin
        res_d.chosen_cpu = item_q.requesting_cpu;
        res_d.found      = 1'b1;
      end
      wits_pkg::DP_NORM: begin
        if (norm_hi) begin
          pos_d = pos_q - NUM_SUB;
        end
      end
      wits_pkg::DP_WALK: begin
        rd_en   = 1'b1;
        rd_addr = pos_adv[CW-1:0];
        pos_d   = pos_adv;
        rd_v_d  = 1'b1;
        cnt_d   = cnt_q - 1'b1;
      end
      wits_pkg::DP_COMMIT: begin
        if (have_q) begin
          last_d           = best_id_q[3:0];
          last_v_d         = 1'b1;
          res_d.chosen_cpu = best_id_q[3:0];
          res_d.found      = 1'b1;
        end
      end
      wits_pkg::DP_RD_TGT: begin
        rd_en = tgt_ok;
      end
      wits_pkg::DP_ADD: begin
        res_d.establish = add_est;
        if (tgt_ok) begin
          wr_en = 1'b1;
          if (sum > SW'(LOAD_MAX)) begin
            wr_data              = LOAD_MAX;
            res_d.applied_weight = room[WW-1:0];
          end else begin
            wr_data              = sum[WEIGHT_BITS-1:0];
            res_d.applied_weight = add_w;
          end
        end
        if (add_w > largest_q) begin
          largest_d = add_w;
        end
      end
      wits_pkg::DP_SUB: begin
        if (tgt_ok) begin
          wr_en = 1'b1;
          if (SW'(sub_w) < SW'(rd_val)) begin
            wr_data              = diff[WEIGHT_BITS-1:0];
            res_d.applied_weight = sub_w;
          end else begin
            // The whole load is removed; it is no larger than the weight.
            wr_data              = '0;
            res_d.applied_weight = WW'(rd_val);
          end
        end
      end
      wits_pkg::DP_REDIST: begin
        vld_d     = '0;
        largest_d = WW'(1);
        res_d.redist_cap = (prod > PRODW'(cfg_i.weight_limit)) ? cfg_i.weight_limit
                                                              : prod[WW-1:0];
      end
      default: ;
    endcase

    if (wr_en) begin
      vld_d[tgt_addr] = 1'b1;
    end
  end

  // Load memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      load_mem[tgt_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_raw_q <= load_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      item_q <= in_data_i;
    end
    res_q       <= res_d;
    best_id_q   <= best_id_d;
    best_load_q <= best_load_d;
    if (op_i == wits_pkg::DP_WALK) begin
      rd_id_q <= pos_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cnt_q     <= '0;
      have_q    <= 1'b0;
      rd_v_q    <= 1'b0;
      rd_hit_q  <= 1'b0;
      last_q    <= '0;
      last_v_q  <= 1'b0;
      largest_q <= WW'(1);
      vld_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      have_q    <= have_d;
      rd_v_q    <= rd_v_d;
      last_q    <= last_d;
      last_v_q  <= last_v_d;
      largest_q <= largest_d;
      vld_q     <= vld_d;
      if (rd_en) begin
        rd_hit_q <= vld_q[rd_addr];
      end
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== src/weighted_interrupt_target_selector.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Weighted interrupt target selector
// Picks the CPU for a device interrupt and keeps per-CPU interrupt loads.
// ---------------------------------------------------------------------------
// One command is in flight at a time; it is accepted only while the
// microsequencer sits at its idle step, and its single result beat goes to
// an output register so the next command can be taken while that beat
// waits. A walking select reads one entry of the load memory per cycle,
// visiting each of the NUM_CPUS entries once, and a result waits at the
// final step while the previous output beat is still stalled.
// Redistribute clears all loads at once through per-entry valid bits, so
// there is no clearing pass after reset. Configuration writes are always
// ready and must only be issued while no command is in flight.
module weighted_interrupt_target_selector #(
  parameter int unsigned NUM_CPUS    = wits_pkg::NUM_CPUS_DEF,
  parameter int unsigned WEIGHT_BITS = wits_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire wits_pkg::in_beat_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output wits_pkg::out_beat_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wits_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wits_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

`include "weighted_interrupt_target_selector_defines.svh"

  wits_pkg::cfg_t      cfg_q;
  wits_pkg::dp_stat_t  stat;
  wits_pkg::dp_op_e    dp_op;
  wits_pkg::out_beat_t res, out_q;
  logic                out_valid_q, out_busy, in_fire, seq_idle, at_fin;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;
  assign at_fin   = (dp_op == wits_pkg::DP_OUT);

  wits_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .op_o       (dp_op),
    .idle_o     (seq_idle)
  );

  wits_dp #(
    .NUM_CPUS    (NUM_CPUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (dp_op),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .stat_o    (stat),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wits_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wits_pkg::CFG_POLICY: cfg_q.policy        <= cfg_data_i[1:0];
        wits_pkg::CFG_ONLINE: cfg_q.online_mask   <= cfg_data_i;
        wits_pkg::CFG_ENABLE: cfg_q.enable_mask   <= cfg_data_i;
        wits_pkg::CFG_FACTOR: cfg_q.weight_factor <= cfg_data_i[wits_pkg::FACTOR_W-1:0];
        wits_pkg::CFG_LIMIT:  cfg_q.weight_limit  <= cfg_data_i[wits_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: loaded at the final step once the previous beat is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (at_fin && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (at_fin && !out_busy) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = !seq_idle;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `WITS_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall_o,
                    "selector accepted a command but did not go busy")
  `WITS_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_q), $past(at_fin),
                    "result beat appeared outside the final microstep")
  `WITS_ASSERT_IMPL(a_select_only_fields, out_valid_q && out_q.found,
                    !out_q.establish && (out_q.applied_weight == '0) &&
                    (out_q.redist_cap == '0),
                    "select result carries weight fields of another command")

endmodule
`default_nettype wire

// ===== verif/tb_weighted_interrupt_target_selector.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted interrupt target selector testbench
// Sends select, add, remove and redistribute commands under a series of
// policy, mask, factor and limit settings. Bursty input traffic and a
// patterned output stall are used. Every result beat is checked field by
// field against an in-bench prediction of the CPU loads and the walk state.
// ---------------------------------------------------------------------------
module tb_weighted_interrupt_target_selector;

  localparam int unsigned LOAD_CEILING = (1 << wits_pkg::WEIGHT_BITS_DEF) - 1;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  // Policy code with no defined meaning and a register index past the list.
  localparam logic [1:0]                     POL_SPARE = 2'd3;
  localparam logic [wits_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  class irq_target_scoreboard;
    logic [1:0]  policy;
    logic [15:0] online;
    logic [15:0] enable;
    logic [4:0]  factor;
    logic [14:0] limit;
    int unsigned cpu_load[16];
    logic [3:0]  last_chosen;
    bit          last_valid;
    logic [14:0] largest;
    wits_pkg::out_beat_t awaited_outcomes[$];
    int          errors;
    int          commands;
    int          checked;

    function new();
      policy      = wits_pkg::CFG_RESET.policy;
      online      = wits_pkg::CFG_RESET.online_mask;
      enable      = wits_pkg::CFG_RESET.enable_mask;
      factor      = wits_pkg::CFG_RESET.weight_factor;
      limit       = wits_pkg::CFG_RESET.weight_limit;
      foreach (cpu_load[i]) cpu_load[i] = 0;
      last_chosen = '0;
      last_valid  = 1'b0;
      largest     = 15'd1;
    endfunction

    function void write_register(logic [wits_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        wits_pkg::CFG_POLICY: policy = value[1:0];
        wits_pkg::CFG_ONLINE: online = value;
        wits_pkg::CFG_ENABLE: enable = value;
        wits_pkg::CFG_FACTOR: factor = value[4:0];
        wits_pkg::CFG_LIMIT:  limit  = value[14:0];
        default: ;
      endcase
    endfunction

    function wits_pkg::out_beat_t target_outcome(wits_pkg::in_beat_t c);
      wits_pkg::out_beat_t o;
      logic [15:0] eligible;
      logic [3:0]  start;
      logic [3:0]  id;
      logic [3:0]  best;
      bit          have;
      int          nw;
      int          dw;
      int unsigned w;
      int unsigned moved;
      int unsigned m;
      o = '0;
      eligible = online & enable;
      nw = $signed(c.nexus_weight);
      dw = $signed(c.device_weight);
      case (c.cmd)
        wits_pkg::CMD_SELECT: begin
          if (policy == wits_pkg::POL_REQ) begin
            o.chosen_cpu = c.requesting_cpu;
            o.found = 1'b1;
          end else begin
            start = last_valid ? last_chosen : c.requesting_cpu;
            have = 1'b0;
            best = '0;
            for (int k = 1; k <= 16; k++) begin
              id = start + 4'(k);
              if (eligible[id]) begin
                // Round robin keeps the first hit; otherwise a strictly
                // smaller load is needed to displace it.
                if (policy == wits_pkg::POL_RR) begin
                  if (!have) begin
                    best = id;
                    have = 1'b1;
                  end
                end else if (!have || cpu_load[id] < cpu_load[best]) begin
                  best = id;
                  have = 1'b1;
                end
              end
            end
            if (have) begin
              o.chosen_cpu = best;
              o.found = 1'b1;
              last_chosen = best;
              last_valid = 1'b1;
            end
          end
        end
        wits_pkg::CMD_ADD: begin
          if (policy == wits_pkg::POL_WLL) begin
            if (dw >= 0) begin
              w = dw;
            end else if (nw > 0) begin
              w = nw;
              o.establish = 1'b1;
            end else begin
              w = 0;
            end
            moved = (w < LOAD_CEILING - cpu_load[c.target_id]) ?
                    w : LOAD_CEILING - cpu_load[c.target_id];
            cpu_load[c.target_id] += moved;
            o.applied_weight = 15'(moved);
            if (w > largest) largest = 15'(w);
          end
        end
        wits_pkg::CMD_REMOVE: begin
          if (policy == wits_pkg::POL_WLL) begin
            w = (dw < 0) ? 0 : dw;
            moved = (w < cpu_load[c.target_id]) ? w : cpu_load[c.target_id];
            cpu_load[c.target_id] -= moved;
            o.applied_weight = 15'(moved);
          end
        end
        default: begin
          foreach (cpu_load[i]) cpu_load[i] = 0;
          m = 32'(largest) * 32'(factor);
          if (m > limit) m = limit;
          largest = 15'd1;
          o.redist_cap = 15'(m);
        end
      endcase
      return o;
    endfunction

    function void note_command(wits_pkg::in_beat_t c);
      commands++;
      awaited_outcomes.push_back(target_outcome(c));
    endfunction

    function void compare_field(string name, logic [14:0] want, logic [14:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(wits_pkg::out_beat_t got);
      wits_pkg::out_beat_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("result beat arrived with no command outstanding");
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      checked++;
      compare_field("chosen_cpu", want.chosen_cpu, got.chosen_cpu);
      compare_field("found", want.found, got.found);
      compare_field("establish", want.establish, got.establish);
      compare_field("applied_weight", want.applied_weight, got.applied_weight);
      compare_field("redist_cap", want.redist_cap, got.redist_cap);
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  wits_pkg::in_beat_t              in_data_i   = '0;
  logic                            out_stall_i = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic [wits_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [wits_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  wits_pkg::out_beat_t             out_data_o;
  logic                            cfg_ready_o;

  irq_target_scoreboard sb;
  int          burst_left = 0;
  int          settings_used = 0;
  int unsigned cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  weighted_interrupt_target_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("weighted_interrupt_target_selector verification failed");
      $finish;
    end
  end

  // The receiver switches between stall patterns, including long clean runs.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(30, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_outcome(out_data_o);
  end

  function automatic wits_pkg::in_beat_t command_beat(logic [1:0] cmd, logic [3:0] req,
                                                      logic [3:0] tgt,
                                                      logic signed [15:0] nw,
                                                      logic signed [15:0] dw);
    wits_pkg::in_beat_t b;
    b.cmd = cmd;
    b.requesting_cpu = req;
    b.target_id = tgt;
    b.nexus_weight = nw;
    b.device_weight = dw;
    return b;
  endfunction

  function automatic logic signed [15:0] random_weight();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = -16'sd32768;
          1:       v = 16'sd32767;
          2:       v = -16'sd1;
          default: v = 16'sd0;
        endcase
      end
      6:       v = 16'($urandom_range(20000, 32767));
      7:       v = -16'($urandom_range(1, 300));
      default: v = 16'($urandom_range(0, 300));
    endcase
    return v;
  endfunction

  function automatic wits_pkg::in_beat_t random_command();
    int                 pick;
    wits_pkg::in_beat_t b;
    pick = $urandom_range(0, 99);
    if (pick < 30)      b.cmd = wits_pkg::CMD_SELECT;
    else if (pick < 66) b.cmd = wits_pkg::CMD_ADD;
    else if (pick < 95) b.cmd = wits_pkg::CMD_REMOVE;
    else                b.cmd = wits_pkg::CMD_REDIST;
    b.requesting_cpu = 4'($urandom);
    // A few hot CPUs let loads climb toward saturation between clears.
    b.target_id = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    b.nexus_weight = random_weight();
    b.device_weight = random_weight();
    return b;
  endfunction

  task automatic send_cmd(input wits_pkg::in_beat_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(beat);
    @(negedge clk_i);
  endtask

  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_register(input logic [wits_pkg::CFG_IDX_W-1:0] idx,
                              input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, value);
    @(negedge clk_i);
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic apply_settings(input logic [1:0] pol, input logic [15:0] on,
                                input logic [15:0] en, input logic [4:0] fac,
                                input logic [14:0] lim, input bit spare);
    put_register(wits_pkg::CFG_POLICY, {14'($urandom), pol});
    put_register(wits_pkg::CFG_ONLINE, on);
    put_register(wits_pkg::CFG_ENABLE, en);
    put_register(wits_pkg::CFG_FACTOR, {11'($urandom), fac});
    put_register(wits_pkg::CFG_LIMIT, {1'($urandom), lim});
    if (spare) put_register(CFG_SPARE, 16'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_cmd(random_command());
    drain_outcomes();
  endtask

  initial begin
    wits_pkg::in_beat_t opening[$];
    logic [1:0]  pol;
    logic [15:0] on;
    logic [15:0] en;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // Reset settings: weighted policy, every CPU eligible.
    opening.push_back(command_beat(wits_pkg::CMD_SELECT, 4'd5, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_SELECT, 4'd0, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd1, 4'd3, 16'sd100, -16'sd1));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd2, 4'd4, -16'sd32768,
                                   -16'sd32768));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd3, 4'd4, 16'sd0, -16'sd1));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd4, 4'd9, -16'sd5, 16'sd0));
    // Three maximal adds to one CPU run its load into saturation.
    repeat (3) opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd15, 4'd15,
                                              16'sd32767, 16'sd32767));
    opening.push_back(command_beat(wits_pkg::CMD_REMOVE, 4'd8, 4'd15, 16'sd0, -16'sd32768));
    opening.push_back(command_beat(wits_pkg::CMD_REMOVE, 4'd9, 4'd3, 16'sd0, 16'sd32767));
    opening.push_back(command_beat(wits_pkg::CMD_REMOVE, 4'd10, 4'd0, 16'sd0, 16'sd5));
    opening.push_back(command_beat(wits_pkg::CMD_SELECT, 4'd15, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_REDIST, 4'd0, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_REDIST, 4'd15, 4'd15, -16'sd1, -16'sd1));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd6, 4'd0, 16'sd32767, -16'sd32768));
    opening.push_back(command_beat(wits_pkg::CMD_ADD, 4'd7, 4'd1, 16'sd1, -16'sd1));
    opening.push_back(command_beat(wits_pkg::CMD_SELECT, 4'd2, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_REMOVE, 4'd11, 4'd0, 16'sd0, 16'sd32767));
    opening.push_back(command_beat(wits_pkg::CMD_SELECT, 4'd0, 4'd0, 16'sd0, 16'sd0));
    opening.push_back(command_beat(wits_pkg::CMD_REDIST, 4'd12, 4'd0, 16'sd0, 16'sd0));
    foreach (opening[i]) send_cmd(opening[i]);
    drain_outcomes();

    apply_settings(wits_pkg::POL_RR, 16'hA5A5, 16'hFFFF, 5'd16, 15'h7FFF, 1'b0);
    run_random(200);
    apply_settings(wits_pkg::POL_REQ, 16'hFFFF, 16'hFFFF, 5'd1, 15'd0, 1'b0);
    run_random(150);
    apply_settings(POL_SPARE, 16'h0F0F, 16'h3C3C, 5'd31, 15'd5000, 1'b0);
    run_random(200);
    // No CPU is eligible in the next two settings.
    apply_settings(wits_pkg::POL_WLL, 16'h0000, 16'hFFFF, 5'd0, 15'h7FFF, 1'b0);
    run_random(100);
    apply_settings(wits_pkg::POL_RR, 16'hFFFF, 16'h0000, 5'd2, 15'd1000, 1'b0);
    run_random(50);
    apply_settings(wits_pkg::POL_WLL, 16'hFFFF, 16'hFFFF, 5'd2, 15'd1000, 1'b1);
    run_random(500);
    apply_settings(wits_pkg::POL_WLL, 16'h8001, 16'hFFFF, 5'd16, 15'h7FFF, 1'b0);
    run_random(350);
    repeat (6) begin
      pol = ($urandom_range(0, 2) == 0) ? 2'($urandom) : wits_pkg::POL_WLL;
      on = ($urandom_range(0, 1) == 0) ? 16'($urandom) : (16'h1 << $urandom_range(0, 15));
      en = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      apply_settings(pol, on, en, 5'($urandom), 15'($urandom), 1'b0);
      run_random(50);
    end

    repeat (30) @(negedge clk_i);
    if (sb.outstanding() != 0) begin
      $error("%0d expected result beats never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Sent %0d commands under %0d register settings; %0d result beats compared.",
             sb.commands, settings_used, sb.checked);
    $display("Mismatches and protocol errors: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("weighted_interrupt_target_selector verification clean");
    end else begin
      $display("weighted_interrupt_target_selector verification failed");
    end
    $finish;
  end
endmodule
